// ===== hw/rtl/dda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and codes of the line rasterizer: opcodes, controller states
// and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package dda_pkg;

  // opcode of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } dda_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture endpoints, start a division
    logic div_step;  // one quotient bit on both axes
    logic div_done;  // turn quotients into signed steps
    logic advance;   // emit a pixel and move the position
  } dda_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic major_zero;  // loaded line has zero length
    logic last;        // pixel being emitted closes the line
  } dda_status_t;

endpackage

// ===== hw/rtl/dda_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_if
// Valid/ready channels of the rasterizer: line command in, pixel out.
// ----------------------------------------------------------------------------
interface dda_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic        [23:0]           line_color;

  modport source (
    output valid, opcode, x_start, y_start, x_end, y_end, line_color,
    input  ready
  );
  modport sink (
    input  valid, opcode, x_start, y_start, x_end, y_end, line_color,
    output ready
  );
endinterface

interface dda_out_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic        [23:0]           pixel_color;
  logic                         last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

// ===== hw/rtl/dda_div_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_div_lane
// Restoring divider lane, one quotient bit per cycle with step high: (mag << FRAC) / major
// with mag <= major, so the quotient has FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
module dda_div_lane #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic [COORD_BITS-1:0] mag_in,
  input  logic [COORD_BITS-1:0] major,
  output logic [FRAC_BITS:0]    quot
);

  logic [COORD_BITS:0] rem_r, rem_nxt;
  logic [FRAC_BITS:0]  quot_r, quot_nxt;
  logic [COORD_BITS:0] major_ext;
  logic [COORD_BITS:0] diff;
  logic                ge;

  // compare, conditional subtract, shift
  always_comb begin
    major_ext = {1'b0, major};
    ge        = rem_r >= major_ext;
    diff      = ge ? (rem_r - major_ext) : rem_r;
    rem_nxt   = {diff[COORD_BITS-1:0], 1'b0};
    quot_nxt  = {quot_r[FRAC_BITS-1:0], ge};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r  <= {1'b0, mag_in};
      quot_r <= '0;
    end else if (step) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;

endmodule

// ===== hw/rtl/dda_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_datapath
// Endpoint capture, per-axis step division, fixed-point position and
// end-distance accumulators, and the pixel output register.
// ----------------------------------------------------------------------------
module dda_datapath
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  dda_cmd_t                     cmd,
  output dda_status_t                  status,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  input  logic        [23:0]           line_color,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic        [23:0]           pixel_color,
  output logic                         last
);

  localparam int PW = COORD_BITS + FRAC_BITS;      // position width
  localparam int EW = COORD_BITS + FRAC_BITS + 1;  // distance-to-end width
  localparam int SW = FRAC_BITS + 2;               // signed step width

  // load-side arithmetic
  logic signed [COORD_BITS:0]   dx, dy, neg_dx, neg_dy;
  logic        [COORD_BITS-1:0] ax, ay, major_in;

  // line state
  logic        [COORD_BITS-1:0] major_r;
  logic                         sign_x_r, sign_y_r;
  logic signed [PW-1:0]         pos_x_r, pos_y_r;
  logic signed [EW-1:0]         err_x_r, err_y_r;
  logic signed [SW-1:0]         step_x_r, step_y_r;
  logic        [23:0]           color_r;

  // step-side arithmetic
  logic        [FRAC_BITS:0]    quot_x, quot_y;
  logic signed [SW-1:0]         qext_x, qext_y;
  logic signed [PW-1:0]         pos_x_nxt, pos_y_nxt;
  logic signed [EW-1:0]         err_x_nxt, err_y_nxt;
  logic                         last_nxt;

  // output register
  logic signed [COORD_BITS-1:0] pixel_x_r, pixel_y_r;
  logic        [23:0]           pixel_color_r;
  logic                         last_r;

  // position truncated toward zero
  function automatic logic [COORD_BITS-1:0] trunc_pix(input logic [PW-1:0] p);
    logic [COORD_BITS-1:0] ip;
    logic                  up;
    ip = p[PW-1:FRAC_BITS];
    up = p[PW-1] & (|p[FRAC_BITS-1:0]);
    return ip + {{(COORD_BITS-1){1'b0}}, up};
  endfunction

  // distance strictly below one pixel
  function automatic logic near_end(input logic [EW-1:0] e);
    logic [COORD_BITS:0] hi;
    hi = e[EW-1:FRAC_BITS];
    return (hi == '0) || ((&hi) && (|e[FRAC_BITS-1:0]));
  endfunction

  // deltas, magnitudes and major length of the incoming line
  always_comb begin
    dx       = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
    dy       = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
    neg_dx   = -dx;
    neg_dy   = -dy;
    ax       = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ay       = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    major_in = (ax > ay) ? ax : ay;
  end

  dda_div_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div_x (
    .clk    (clk),
    .load   (cmd.load),
    .step   (cmd.div_step),
    .mag_in (ax),
    .major  (major_r),
    .quot   (quot_x)
  );

  dda_div_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div_y (
    .clk    (clk),
    .load   (cmd.load),
    .step   (cmd.div_step),
    .mag_in (ay),
    .major  (major_r),
    .quot   (quot_y)
  );

  // position and end distance after one step
  always_comb begin
    qext_x    = {1'b0, quot_x};
    qext_y    = {1'b0, quot_y};
    pos_x_nxt = pos_x_r + {{(PW-SW){step_x_r[SW-1]}}, step_x_r};
    pos_y_nxt = pos_y_r + {{(PW-SW){step_y_r[SW-1]}}, step_y_r};
    err_x_nxt = err_x_r + {{(EW-SW){step_x_r[SW-1]}}, step_x_r};
    err_y_nxt = err_y_r + {{(EW-SW){step_y_r[SW-1]}}, step_y_r};
    last_nxt  = near_end(err_x_nxt) && near_end(err_y_nxt);
  end

  // line state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      major_r  <= major_in;
      sign_x_r <= dx[COORD_BITS];
      sign_y_r <= dy[COORD_BITS];
      pos_x_r  <= {x_start, {FRAC_BITS{1'b0}}};
      pos_y_r  <= {y_start, {FRAC_BITS{1'b0}}};
      err_x_r  <= {neg_dx, {FRAC_BITS{1'b0}}};
      err_y_r  <= {neg_dy, {FRAC_BITS{1'b0}}};
      color_r  <= line_color;
    end else if (cmd.advance) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      err_x_r <= err_x_nxt;
      err_y_r <= err_y_nxt;
    end
    if (cmd.div_done) begin
      step_x_r <= sign_x_r ? -qext_x : qext_x;
      step_y_r <= sign_y_r ? -qext_y : qext_y;
    end
  end

  // pixel output register
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      pixel_x_r     <= trunc_pix(pos_x_r);
      pixel_y_r     <= trunc_pix(pos_y_r);
      pixel_color_r <= color_r;
      last_r        <= last_nxt;
    end
  end

  assign status.major_zero = (major_r == '0);
  assign status.last       = last_nxt;

  assign pixel_x     = pixel_x_r;
  assign pixel_y     = pixel_y_r;
  assign pixel_color = pixel_color_r;
  assign last        = last_r;

endmodule

// ===== hw/rtl/dda_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_ctrl
// Sequencer of the rasterizer: input handshake, division count, line
// activity and the valid flag of the pixel output register.
// ----------------------------------------------------------------------------
module dda_ctrl
  import dda_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_opcode,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output dda_cmd_t    cmd,
  input  dda_status_t status
);

  localparam int CNT_W = $clog2(FRAC_BITS + 2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS + 1);

  dda_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  // state, counter and output flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    in_ready     = (state_r != ST_DIV) && (!out_valid_r || out_ready);
    accept       = in_valid && in_ready;

    case (state_r)
      ST_IDLE, ST_RUN: begin
        if (accept && (in_opcode == OP_LOAD)) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end else if (accept && (state_r == ST_RUN)) begin
          cmd.advance = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if ((cnt_r == '0) && status.major_zero) begin
          state_nxt = ST_IDLE;
        end else if (cnt_r == CNT_LAST) begin
          cmd.div_done = 1'b1;
          state_nxt    = ST_RUN;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // output register holds until taken
    if (cmd.advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // no input word taken while dividing
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !in_ready)
    else $error("input accepted during division");

  // a pixel is only produced for an active line
  a_advance_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (state_r == ST_RUN))
    else $error("pixel emitted with no active line");

  // the closing pixel ends the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && status.last) |=> (state_r == ST_IDLE))
    else $error("line still active after last pixel");

  // division count stays in range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= CNT_LAST))
    else $error("division counter out of range");

  // a pending pixel is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.advance)
    else $error("output word overwritten before it was taken");

endmodule

// ===== hw/rtl/dda_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line stepper: a load word sets up a line, each step word on an active
// line emits one pixel, truncated toward zero, flagged last on the final pixel.
// ----------------------------------------------------------------------------
//  port      dir   contents
//  --------  ----  -----------------------------------------------------------
//  in_ch     in    opcode, x_start, y_start, x_end, y_end, line_color
//  out_ch    out   pixel_x, pixel_y, pixel_color, last
//
//  Pixels stream at one per clock while step words keep coming and out_ch.ready
//  stays high. A load word keeps the input closed while the bit-serial divider
//  forms FRAC_BITS + 1 quotient bits, one per cycle on both axes, and then
//  applies the final sign fix; a zero-length line closes it too but skips the
//  division.
//  Reset is synchronous, active low, and leaves no line active.
//  The pixel output register lets a step word in while the previous pixel is
//  taken; with that register full and out_ch.ready low, in_ch.ready drops.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dda_in_if.sink    in_ch,
  dda_out_if.source out_ch
);

  dda_cmd_t    cmd;
  dda_status_t status;

  dda_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .x_start     (in_ch.x_start),
    .y_start     (in_ch.y_start),
    .x_end       (in_ch.x_end),
    .y_end       (in_ch.y_end),
    .line_color  (in_ch.line_color),
    .pixel_x     (out_ch.pixel_x),
    .pixel_y     (out_ch.pixel_y),
    .pixel_color (out_ch.pixel_color),
    .last        (out_ch.last)
  );

endmodule

// ===== test/tb_dda_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// Self-checking bench for the DDA line stepper. Load and step words are sent
// in bursts with random gaps while the pixel side stalls on its own pattern.
// A line-stepping model in the bench predicts every pixel, and each pixel
// taken from the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer;
  import dda_pkg::*;

  localparam int    COORD_BITS   = 12;
  localparam int    FRAC_BITS    = 16;
  localparam longint ONE_PIXEL   = longint'(1) << FRAC_BITS;
  localparam int    WORDS_TARGET = 1200;
  localparam int    STALL_LIMIT  = 4000;
  localparam int    MAX_REPORTS  = 10;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one input word
  typedef struct packed {
    logic        op;
    coord_t      xs;
    coord_t      ys;
    coord_t      xe;
    coord_t      ye;
    logic [23:0] color;
  } line_word_t;

  // one predicted pixel
  typedef struct packed {
    coord_t      px;
    coord_t      py;
    logic [23:0] color;
    logic        last;
  } pixel_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_t;

  logic clk;
  logic rst_n;

  dda_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  dda_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  dda_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // line stepper state of the model
  logic signed [27:0] pos_x, pos_y;
  coord_t             tgt_x, tgt_y;
  logic signed [17:0] stp_x, stp_y;
  logic [23:0]        line_rgb;
  logic               line_active;

  pixel_t pixel_queue[$];

  int error_count;
  int words_sent;
  int lines_loaded;
  int pixels_checked;
  int lines_closed;
  int burst_left;
  int idle_cycles;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // fixed point to pixel, truncating toward zero
  function automatic longint to_pixel(longint fx);
    if (fx < 0) return -((-fx) >> FRAC_BITS);
    return fx >> FRAC_BITS;
  endfunction

  // signed per-axis increment, quotient truncated toward zero
  function automatic longint axis_step(longint d, longint major);
    longint q;
    q = ((d < 0 ? -d : d) << FRAC_BITS) / major;
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint line_major(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    longint ax, ay;
    ax = longint'(xe) - longint'(xs);
    ay = longint'(ye) - longint'(ys);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    return (ax > ay) ? ax : ay;
  endfunction

  // advance the model by one accepted word, queue the pixel it makes
  task automatic rasterize_word(input line_word_t w);
    longint major, px, py, ex, ey;
    pixel_t pix;
    if (w.op == OP_LOAD) begin
      major    = line_major(w.xs, w.ys, w.xe, w.ye);
      line_rgb = w.color;
      tgt_x    = w.xe;
      tgt_y    = w.ye;
      pos_x    = longint'(w.xs) * ONE_PIXEL;
      pos_y    = longint'(w.ys) * ONE_PIXEL;
      if (major == 0) begin
        stp_x       = '0;
        stp_y       = '0;
        line_active = 1'b0;
      end else begin
        stp_x       = axis_step(longint'(w.xe) - longint'(w.xs), major);
        stp_y       = axis_step(longint'(w.ye) - longint'(w.ys), major);
        line_active = 1'b1;
      end
      lines_loaded++;
    end else if (line_active) begin
      px    = to_pixel(longint'(pos_x));
      py    = to_pixel(longint'(pos_y));
      pos_x = longint'(pos_x) + longint'(stp_x);
      pos_y = longint'(pos_y) + longint'(stp_y);
      ex    = longint'(pos_x) - longint'(tgt_x) * ONE_PIXEL;
      ey    = longint'(pos_y) - longint'(tgt_y) * ONE_PIXEL;
      if (ex < 0) ex = -ex;
      if (ey < 0) ey = -ey;
      pix.px    = px[COORD_BITS-1:0];
      pix.py    = py[COORD_BITS-1:0];
      pix.color = line_rgb;
      pix.last  = (ex < ONE_PIXEL) && (ey < ONE_PIXEL);
      if (pix.last) line_active = 1'b0;
      pixel_queue.push_back(pix);
    end
  endtask

  function automatic line_word_t load_word(int xs, int ys, int xe, int ye, logic [23:0] rgb);
    line_word_t w;
    w.op    = OP_LOAD;
    w.xs    = xs[COORD_BITS-1:0];
    w.ys    = ys[COORD_BITS-1:0];
    w.xe    = xe[COORD_BITS-1:0];
    w.ye    = ye[COORD_BITS-1:0];
    w.color = rgb;
    return w;
  endfunction

  // step word with junk in the unused fields
  function automatic line_word_t step_word();
    line_word_t w;
    w.op    = OP_STEP;
    w.xs    = $urandom;
    w.ys    = $urandom;
    w.xe    = $urandom;
    w.ye    = $urandom;
    w.color = $urandom;
    return w;
  endfunction

  // send one word, then keep the burst going or open a gap
  task automatic send_word(input line_word_t w);
    in_ch.opcode     = w.op;
    in_ch.x_start    = w.xs;
    in_ch.y_start    = w.ys;
    in_ch.x_end      = w.xe;
    in_ch.y_end      = w.ye;
    in_ch.line_color = w.color;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    rasterize_word(w);
    words_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid      = 1'b0;
      in_ch.line_color = $urandom;
      repeat ($urandom_range(2) == 0 ? 0 : $urandom_range(1, 7)) @(negedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic send_steps(input int count);
    repeat (count) send_word(step_word());
  endtask

  // random endpoint pair with each axis delta within +-span
  task automatic pick_line(input int span, output int xs, ys, xe, ye);
    int dx, dy;
    xs = $signed(coord_t'($urandom));
    ys = $signed(coord_t'($urandom));
    dx = $urandom_range(0, 2 * span) - span;
    dy = $urandom_range(0, 2 * span) - span;
    xe = xs + dx;
    ye = ys + dy;
    if (xe > 2047 || xe < -2048) xe = xs - dx;
    if (ye > 2047 || ye < -2048) ye = ys - dy;
  endtask

  // step words before any line is loaded
  task automatic test_idle_steps();
    send_steps(2);
  endtask

  // zero length, short lines run past their end, extreme diagonals cut by reloads
  task automatic test_directed_lines();
    send_word(load_word(5, 5, 5, 5, 24'h000000));
    send_steps(1);
    send_word(load_word(0, 0, 3, -5, 24'hFFFFFF));
    send_steps(6);
    send_word(load_word(-2048, -2048, 2047, 2047, 24'h123456));
    send_steps(3);
    send_word(load_word(2047, -2048, -2048, 2047, 24'hA5A5A5));
    send_steps(3);
    send_word(load_word(-3, 4, -1, 4, 24'h5A5A5A));
    send_steps(3);
  endtask

  // mostly complete short lines, some long ones cut short, some stray steps
  task automatic test_random_lines();
    int     xs, ys, xe, ye, kind, major, steps;
    while (words_sent < WORDS_TARGET) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        send_steps($urandom_range(1, 3));
      end else begin
        if (kind < 82) pick_line(24, xs, ys, xe, ye);
        else if (kind < 94) pick_line(300, xs, ys, xe, ye);
        else begin
          xs = $signed(coord_t'($urandom));
          ys = $signed(coord_t'($urandom));
          xe = $signed(coord_t'($urandom));
          ye = $signed(coord_t'($urandom));
        end
        if ($urandom_range(15) == 0) begin
          xe = xs;
          ye = ys;
        end
        send_word(load_word(xs, ys, xe, ye, $urandom));
        major = line_major(xs, ys, xe, ye);
        if (kind >= 94 || $urandom_range(6) == 0) steps = $urandom_range(0, major < 40 ? major : 40);
        else steps = major + $urandom_range(0, 2);
        send_steps(steps);
      end
    end
  endtask

  // pixel checker
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixel_queue.size() == 0) begin
        note_error($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                             out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color, out_ch.last));
      end else begin
        want = pixel_queue.pop_front();
        pixels_checked++;
        if (want.last) lines_closed++;
        if (out_ch.pixel_x !== want.px || out_ch.pixel_y !== want.py ||
            out_ch.pixel_color !== want.color || out_ch.last !== want.last) begin
          note_error($sformatf(
            "pixel %0d: exp x=%0d y=%0d color=%06h last=%0b, got x=%0d y=%0d color=%06h last=%0b",
            pixels_checked, want.px, want.py, want.color, want.last,
            out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color, out_ch.last));
        end
      end
    end
  end

  // pixel side back-pressure
  rx_mode_t rx_mode;
  int       rx_left;
  int       rx_hold;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ch.ready = 1'b1;
      RX_COIN:   out_ch.ready = $urandom_range(1);
      RX_SPARSE: out_ch.ready = ($urandom_range(3) == 0);
      default: begin
        if (rx_hold > 0) begin
          out_ch.ready = 1'b0;
          rx_hold--;
        end else begin
          out_ch.ready = 1'b1;
          if ($urandom_range(7) == 0) rx_hold = $urandom_range(4, 16);
        end
      end
    endcase
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("tb_dda_line_rasterizer: done, errors");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_LOAD;
    in_ch.x_start    = '0;
    in_ch.y_start    = '0;
    in_ch.x_end      = '0;
    in_ch.y_end      = '0;
    in_ch.line_color = '0;
    out_ch.ready     = 1'b0;
    rx_mode          = RX_OPEN;
    rx_left          = 0;
    rx_hold          = 0;
    idle_cycles      = 0;
    burst_left       = 0;
    error_count      = 0;
    words_sent       = 0;
    lines_loaded     = 0;
    pixels_checked   = 0;
    lines_closed     = 0;
    pos_x            = '0;
    pos_y            = '0;
    tgt_x            = '0;
    tgt_y            = '0;
    stp_x            = '0;
    stp_y            = '0;
    line_rgb         = '0;
    line_active      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_steps();
    test_directed_lines();
    test_random_lines();

    // drain the pixel queue, then allow for a divider pass
    in_ch.valid = 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (FRAC_BITS + 8) @(posedge clk);

    if (pixel_queue.size() != 0) note_error("pixels still expected at end of run");
    $display("covered %0d words, %0d line loads, %0d pixels checked, %0d lines ended",
             words_sent, lines_loaded, pixels_checked, lines_closed);
    $display("mismatches and stray pixels: %0d", error_count);
    if (error_count == 0) begin
      $display("tb_dda_line_rasterizer: done, clean");
    end else begin
      $display("tb_dda_line_rasterizer: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dda_pkg.sv
hw/rtl/dda_if.sv
hw/rtl/dda_div_lane.sv
hw/rtl/dda_datapath.sv
hw/rtl/dda_ctrl.sv
hw/rtl/dda_line_rasterizer.sv
test/tb_dda_line_rasterizer.sv
